// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion shorthands clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/rrtp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtp_pkg
// Shared constants and types of the round-robin task picker.
// ----------------------------------------------------------------------------
package rrtp_pkg;

  localparam int MAX_TASKS_DEF = 64;
  localparam int NUM_CPUS_DEF  = 4;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_SCHED  = 2'd1,
    OP_TERM   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RS_DONE    = 2'd0,
    RS_FULL    = 2'd1,
    RS_NO_TASK = 2'd2,
    RS_IDLE    = 2'd3
  } resp_t;

  typedef enum logic [1:0] {
    TS_UNUSED  = 2'd0,
    TS_READY   = 2'd1,
    TS_RUNNING = 2'd2,
    TS_DEAD    = 2'd3
  } tstate_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_CUR  = 2'd1,
    FSM_WALK = 2'd2
  } fsm_t;

endpackage

// ----- design/round_robin_task_picker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_picker
// Multi-CPU round-robin task picker over a ring of task slots.
//
// in_*  : one request item. tuser holds the operation (create, schedule,
//         terminate, lookup); tdata holds the CPU and the slot for lookup.
// out_* : one result item per request: slot number and status code.
// Create, lookup, terminate and rejected requests finish in the accept cycle;
// the result is registered and shows in the next cycle. Schedule reads the
// current task, then walks the ring one slot per cycle through the task table
// RAM (one read per cycle, registered read data), visiting at most MAX_TASKS
// slots; a CPU without a task skips the read of the current task. One request
// is in work at a time; a new item is accepted once the block is idle and the
// output register is empty or being drained.
// Reset puts slot 0 running on CPU 0 with a self link; other CPUs have no task.
// The task table needs no clearing pass: slots above the create count are
// never read. A stalled receiver holds the result and blocks new items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_task_picker #(
  parameter int MAX_TASKS = rrtp_pkg::MAX_TASKS_DEF,
  parameter int NUM_CPUS  = rrtp_pkg::NUM_CPUS_DEF,
  localparam int SLOT_W   = $clog2(MAX_TASKS),
  localparam int CPU_W    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1,
  localparam int IN_W     = 8 * ((CPU_W + SLOT_W + 7) / 8),
  localparam int OUT_W    = 8 * ((SLOT_W + 7) / 8)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // cpu, task_id
  input  logic [1:0]       in_tuser,   // op
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // task_res
  output logic [1:0]       out_tuser   // status
);
  import rrtp_pkg::*;

  localparam int OWN_W = $clog2(NUM_CPUS + 1);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int ENT_W = 2 + OWN_W;
  localparam logic [OWN_W-1:0]  OWN_NONE  = OWN_W'(NUM_CPUS);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_TASKS);
  localparam logic [SLOT_W-1:0] WALK_LAST = SLOT_W'(MAX_TASKS - 1);

  op_t               in_op;
  logic [CPU_W-1:0]  in_cpu;
  logic [SLOT_W-1:0] in_id;
  logic              in_acc;
  logic              cpu_ok;

  fsm_t              state_r, state_nxt;
  logic [CPU_W-1:0]  job_cpu_r, job_cpu_nxt;
  logic [SLOT_W-1:0] job_cur_r, job_cur_nxt;
  logic              job_has_r, job_has_nxt;
  logic              cdead_r, cdead_nxt;
  logic [SLOT_W-1:0] stop_r, stop_nxt;
  logic [SLOT_W-1:0] walk_cnt_r, walk_cnt_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [1:0]        s0_st_r;
  logic [OWN_W-1:0]  s0_own_r;

  logic [SLOT_W-1:0] cpu_cur_r [NUM_CPUS];
  logic [SLOT_W-1:0] cpu_cur_nxt [NUM_CPUS];
  logic [NUM_CPUS-1:0] cpu_has_r, cpu_has_nxt;
  logic [NUM_CPUS-1:0] cpu_halt_r, cpu_halt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] res_r, res_nxt;
  logic [1:0]        status_r, status_nxt;

  logic              st_we;
  logic [SLOT_W-1:0] st_waddr;
  logic [ENT_W-1:0]  st_wdata;
  logic              ln_we;
  logic [SLOT_W-1:0] ln_waddr;
  logic [SLOT_W-1:0] ln_wdata;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] rd_addr_r;
  logic [ENT_W-1:0]  st_rdata;
  logic [SLOT_W-1:0] ln_rdata;
  logic              fwd_r;
  logic [ENT_W-1:0]  fwd_data_r;

  logic [1:0]        cur_st;
  logic [OWN_W-1:0]  cur_own;
  logic [SLOT_W-1:0] cur_next;

  assign in_op  = op_t'(in_tuser);
  assign in_cpu = in_tdata[CPU_W-1:0];
  assign in_id  = in_tdata[CPU_W +: SLOT_W];
  assign cpu_ok = ({1'b0, in_cpu} < (CPU_W + 1)'(NUM_CPUS));

  assign in_tready  = (state_r == FSM_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(res_r);
  assign out_tuser  = status_r;

  rrtp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we && (st_waddr != '0)),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  rrtp_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_TASKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ln_we),
    .waddr (ln_waddr),
    .wdata (ln_wdata),
    .raddr (rd_addr),
    .rdata (ln_rdata)
  );

  // Slot 0 lives in flops; other slots come from RAM, with write forwarding on the state entries.
  always_comb begin
    if (rd_addr_r == '0) begin
      cur_st   = s0_st_r;
      cur_own  = s0_own_r;
      cur_next = head_r;
    end else if (fwd_r) begin
      cur_st   = fwd_data_r[ENT_W-1 -: 2];
      cur_own  = fwd_data_r[OWN_W-1:0];
      cur_next = ln_rdata;
    end else begin
      cur_st   = st_rdata[ENT_W-1 -: 2];
      cur_own  = st_rdata[OWN_W-1:0];
      cur_next = ln_rdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_cpu_nxt   = job_cpu_r;
    job_cur_nxt   = job_cur_r;
    job_has_nxt   = job_has_r;
    cdead_nxt     = cdead_r;
    stop_nxt      = stop_r;
    walk_cnt_nxt  = walk_cnt_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    cpu_cur_nxt   = cpu_cur_r;
    cpu_has_nxt   = cpu_has_r;
    cpu_halt_nxt  = cpu_halt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    res_nxt       = res_r;
    status_nxt    = status_r;
    st_we         = 1'b0;
    st_waddr      = '0;
    st_wdata      = '0;
    ln_we         = 1'b0;
    ln_waddr      = '0;
    ln_wdata      = '0;
    rd_addr       = '0;

    case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          status_nxt    = RS_DONE;
          case (in_op)
            OP_CREATE: begin
              if (count_r == CNT_FULL) begin
                status_nxt = RS_FULL;
              end else begin
                st_we     = 1'b1;
                st_waddr  = count_r[SLOT_W-1:0];
                st_wdata  = {TS_READY, OWN_NONE};
                ln_we     = 1'b1;
                ln_waddr  = count_r[SLOT_W-1:0];
                ln_wdata  = head_r;
                head_nxt  = count_r[SLOT_W-1:0];
                count_nxt = count_r + CNT_W'(1);
                res_nxt   = count_r[SLOT_W-1:0];
              end
            end
            OP_LOOKUP: begin
              if (CNT_W'(in_id) < count_r) begin
                res_nxt = in_id;
              end else begin
                status_nxt = RS_NO_TASK;
              end
            end
            default: begin
              if (!cpu_ok || cpu_halt_r[in_cpu]) begin
                status_nxt = RS_IDLE;
              end else if (in_op == OP_TERM) begin
                if (!cpu_has_r[in_cpu]) begin
                  status_nxt = RS_IDLE;
                end else begin
                  st_we    = 1'b1;
                  st_waddr = cpu_cur_r[in_cpu];
                  st_wdata = {TS_DEAD, OWN_W'(in_cpu)};
                  res_nxt  = cpu_cur_r[in_cpu];
                end
              end else begin
                out_valid_nxt = 1'b0;
                job_cpu_nxt   = in_cpu;
                job_has_nxt   = cpu_has_r[in_cpu];
                job_cur_nxt   = cpu_cur_r[in_cpu];
                cdead_nxt     = 1'b0;
                stop_nxt      = '0;
                walk_cnt_nxt  = '0;
                if (cpu_has_r[in_cpu]) begin
                  rd_addr   = cpu_cur_r[in_cpu];
                  state_nxt = FSM_CUR;
                end else begin
                  rd_addr   = '0;
                  state_nxt = FSM_WALK;
                end
              end
            end
          endcase
        end
      end

      FSM_CUR: begin
        // Release the running task, then start the walk at its successor.
        cdead_nxt = (cur_st == TS_DEAD);
        if (cur_st == TS_RUNNING) begin
          st_we    = 1'b1;
          st_waddr = job_cur_r;
          st_wdata = {TS_READY, OWN_NONE};
        end
        rd_addr      = cur_next;
        stop_nxt     = job_cur_r;
        walk_cnt_nxt = '0;
        state_nxt    = FSM_WALK;
      end

      FSM_WALK: begin
        if (cur_st == TS_READY && cur_own == OWN_NONE) begin
          st_we                  = 1'b1;
          st_waddr               = rd_addr_r;
          st_wdata               = {TS_RUNNING, OWN_W'(job_cpu_r)};
          cpu_cur_nxt[job_cpu_r] = rd_addr_r;
          cpu_has_nxt[job_cpu_r] = 1'b1;
          out_valid_nxt          = 1'b1;
          res_nxt                = rd_addr_r;
          status_nxt             = RS_DONE;
          state_nxt              = FSM_IDLE;
        end else if (cur_next == stop_r || walk_cnt_r == WALK_LAST) begin
          out_valid_nxt = 1'b1;
          state_nxt     = FSM_IDLE;
          if (job_has_r && !cdead_r) begin
            st_we                  = 1'b1;
            st_waddr               = job_cur_r;
            st_wdata               = {TS_RUNNING, OWN_W'(job_cpu_r)};
            cpu_cur_nxt[job_cpu_r] = job_cur_r;
            cpu_has_nxt[job_cpu_r] = 1'b1;
            res_nxt                = job_cur_r;
            status_nxt             = RS_DONE;
          end else begin
            if (job_has_r) begin
              cpu_halt_nxt[job_cpu_r] = 1'b1;
              cpu_has_nxt[job_cpu_r]  = 1'b0;
            end
            res_nxt    = '0;
            status_nxt = RS_IDLE;
          end
        end else begin
          rd_addr      = cur_next;
          walk_cnt_nxt = walk_cnt_r + SLOT_W'(1);
        end
      end

      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= CNT_W'(1);
      head_r      <= '0;
      s0_st_r     <= TS_RUNNING;
      s0_own_r    <= '0;
      cpu_has_r   <= NUM_CPUS'(1);
      cpu_halt_r  <= '0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        cpu_cur_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      cpu_cur_r   <= cpu_cur_nxt;
      cpu_has_r   <= cpu_has_nxt;
      cpu_halt_r  <= cpu_halt_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= st_we && (st_waddr == rd_addr) && (rd_addr != '0);
      if (st_we && (st_waddr == '0)) begin
        s0_st_r  <= st_wdata[ENT_W-1 -: 2];
        s0_own_r <= st_wdata[OWN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    job_cpu_r  <= job_cpu_nxt;
    job_cur_r  <= job_cur_nxt;
    job_has_r  <= job_has_nxt;
    cdead_r    <= cdead_nxt;
    stop_r     <= stop_nxt;
    walk_cnt_r <= walk_cnt_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    rd_addr_r  <= rd_addr;
    fwd_data_r <= st_wdata;
  end

  `ASSERT_ALWAYS(a_busy_no_out, (state_r == FSM_IDLE) || !out_valid_r, "result pending while busy")
  `ASSERT_ALWAYS(a_halt_no_task, (cpu_halt_r & cpu_has_r) == '0, "halted cpu holds a task")
  `ASSERT_ALWAYS(a_count_max, count_r <= CNT_FULL, "task count above table size")
  `ASSERT_NEXT(a_count_mono, 1'b1, count_r >= $past(count_r), "task count went down")

endmodule

// ----- design/rrtp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the round-robin task picker.
//
// Requests go in as items of operation, CPU and slot. Each accepted item runs
// through a task table model held in the scoreboard. That model yields the
// slot and status to expect, and each reply is compared against the oldest
// one. A short directed part covers:
//   - lookups at the table edges,
//   - a CPU without a task,
//   - a CPU that keeps its task,
//   - a CPU halted on a dead task.
// The random part then fills the table to full under mixed traffic. Both
// sides idle at random, and the receiver once holds off long enough to back
// up the input.
// ----------------------------------------------------------------------------
module tb;
  import rrtp_pkg::*;

  localparam int SLOTS      = MAX_TASKS_DEF;
  localparam int CPUS       = NUM_CPUS_DEF;
  localparam int N_RANDOM   = 1280;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = SLOTS + 16;

  typedef struct packed {
    logic [5:0] slot;
    resp_t      status;
  } reply_t;

  class picker_scoreboard;
    localparam logic [2:0] NO_OWNER = 3'(CPUS);

    tstate_t     slot_state[SLOTS];
    logic [2:0]  slot_owner[SLOTS];
    logic [5:0]  slot_link[SLOTS];
    logic [5:0]  cur_slot[CPUS];
    bit          has_task[CPUS];
    bit          halted[CPUS];
    int unsigned n_created;

    reply_t      pending_replies[$];
    int          errors;
    int          n_op[4];
    int          n_full, n_no_task, n_idle, n_halts;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] = TS_UNUSED;
        slot_owner[i] = NO_OWNER;
        slot_link[i]  = '0;
      end
      for (int i = 0; i < CPUS; i++) begin
        cur_slot[i] = '0;
        has_task[i] = 1'b0;
        halted[i]   = 1'b0;
      end
      slot_state[0] = TS_RUNNING;
      slot_owner[0] = 3'd0;
      has_task[0]   = 1'b1;
      n_created     = 1;
    endfunction

    function bit free_ready(logic [5:0] s);
      return slot_state[s] == TS_READY && slot_owner[s] == NO_OWNER;
    endfunction

    // first free ready slot from start, stopping on return to stop_at; -1 if none
    function int find_ready(logic [5:0] start, logic [5:0] stop_at);
      logic [5:0] n;
      n = start;
      for (int i = 0; i < SLOTS; i++) begin
        if (free_ready(n)) return int'(n);
        n = slot_link[n];
        if (n == stop_at) return -1;
      end
      return -1;
    endfunction

    function void note_request(op_t op, logic [1:0] cpu, logic [5:0] id);
      reply_t     r;
      int         pick;
      logic [5:0] c;
      r.slot   = '0;
      r.status = RS_DONE;
      n_op[op]++;
      case (op)
        OP_CREATE: begin
          if (n_created >= SLOTS) begin
            r.status = RS_FULL;
          end else begin
            c = 6'(n_created);
            slot_state[c] = TS_READY;
            slot_owner[c] = NO_OWNER;
            slot_link[c]  = slot_link[0];
            slot_link[0]  = c;
            n_created++;
            r.slot = c;
          end
        end
        OP_LOOKUP: begin
          if (id < n_created) r.slot = id;
          else r.status = RS_NO_TASK;
        end
        OP_TERM: begin
          if (halted[cpu] || !has_task[cpu]) begin
            r.status = RS_IDLE;
          end else begin
            c = cur_slot[cpu];
            slot_state[c] = TS_DEAD;
            r.slot = c;
          end
        end
        default: begin
          if (halted[cpu]) begin
            r.status = RS_IDLE;
          end else begin
            if (!has_task[cpu]) begin
              pick = find_ready(6'd0, 6'd0);
            end else begin
              c = cur_slot[cpu];
              if (slot_state[c] == TS_RUNNING) begin
                slot_state[c] = TS_READY;
                slot_owner[c] = NO_OWNER;
              end
              pick = find_ready(slot_link[c], c);
              if (pick < 0) begin
                if (slot_state[c] != TS_DEAD) begin
                  pick = int'(c);
                end else begin
                  halted[cpu]   = 1'b1;
                  has_task[cpu] = 1'b0;
                  n_halts++;
                end
              end
            end
            if (pick < 0) begin
              r.status = RS_IDLE;
            end else begin
              c = 6'(pick);
              cur_slot[cpu]   = c;
              has_task[cpu]   = 1'b1;
              slot_state[c]   = TS_RUNNING;
              slot_owner[c]   = 3'(cpu);
              r.slot = c;
            end
          end
        end
      endcase
      case (r.status)
        RS_FULL:    n_full++;
        RS_NO_TASK: n_no_task++;
        RS_IDLE:    n_idle++;
        default:    ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [5:0] slot, logic [1:0] status);
      reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with nothing pending: expected none, got slot %0d status %0d",
                 $time, slot, status);
        errors++;
        return;
      end
      exp_r = pending_replies.pop_front();
      if (slot !== exp_r.slot) begin
        $display("%0t: slot mismatch: expected %0d, got %0d", $time, exp_r.slot, slot);
        errors++;
      end
      if (status !== exp_r.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $time, exp_r.status, status);
        errors++;
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;   // cpu, task_id
  logic [1:0] in_tuser   = '0;   // op
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // task_res
  logic [1:0] out_tuser;         // status

  picker_scoreboard picker;
  int  n_sent       = 0;
  int  n_cycles     = 0;
  int  hold_left    = 0;
  bit  backed_up    = 1'b0;

  round_robin_task_picker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // receiver: check replies, stall at random, back up the block once
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      picker.check_reply(out_tdata[5:0], out_tuser);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!backed_up && n_sent >= 400) begin
      backed_up = 1'b1;
      hold_left = 300;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if ((n_cycles / 500) % 4 != 1 && $urandom_range(0, 99) < 20) begin
      hold_left = pick_gap();
      out_tready <= (hold_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic issue(op_t op, logic [1:0] cpu, logic [5:0] id);
    int gap;
    gap = ((n_sent / 150) % 4 == 3) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {id, cpu};
    do @(posedge clk); while (!in_tready);
    picker.note_request(op, cpu, id);
    n_sent++;
  endtask

  task automatic issue_random();
    int         r;
    op_t        op;
    logic [5:0] id;
    r = $urandom_range(0, 99);
    if (r < 7) op = OP_CREATE;
    else if (r < 11) op = OP_TERM;
    else if (r < 60) op = OP_SCHED;
    else op = OP_LOOKUP;
    if ($urandom_range(0, 1)) id = 6'($urandom_range(0, SLOTS - 1));
    else id = 6'(picker.n_created + $urandom_range(0, 2) - 1);
    issue(op, 2'($urandom_range(0, CPUS - 1)), id);
  endtask

  initial begin
    picker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_LOOKUP, 2'd0, 6'd0);
    issue(OP_LOOKUP, 2'd1, 6'd63);
    issue(OP_LOOKUP, 2'd2, 6'd1);
    issue(OP_TERM,   2'd1, 6'd0);
    issue(OP_SCHED,  2'd1, 6'd0);
    issue(OP_SCHED,  2'd0, 6'd0);
    issue(OP_CREATE, 2'd0, 6'd0);
    issue(OP_SCHED,  2'd3, 6'd0);
    issue(OP_TERM,   2'd3, 6'd0);
    issue(OP_SCHED,  2'd3, 6'd0);
    issue(OP_SCHED,  2'd3, 6'd0);
    issue(OP_TERM,   2'd3, 6'd0);
    issue(OP_CREATE, 2'd3, 6'd63);
    issue(OP_SCHED,  2'd0, 6'd0);
    issue(OP_SCHED,  2'd1, 6'd0);
    issue(OP_SCHED,  2'd2, 6'd0);
    issue(OP_CREATE, 2'd2, 6'd42);
    issue(OP_SCHED,  2'd2, 6'd21);
    issue(OP_LOOKUP, 2'd3, 6'd3);
    issue(OP_LOOKUP, 2'd0, 6'd4);
    issue(OP_TERM,   2'd0, 6'd0);
    issue(OP_SCHED,  2'd0, 6'd0);
    issue(OP_SCHED,  2'd1, 6'd0);

    for (int k = 0; k < N_RANDOM; k++) issue_random();
    in_tvalid <= 1'b0;

    while (picker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d requests: %0d create, %0d schedule, %0d terminate, %0d lookup",
             n_sent, picker.n_op[OP_CREATE], picker.n_op[OP_SCHED],
             picker.n_op[OP_TERM], picker.n_op[OP_LOOKUP]);
    $display("Saw %0d table full, %0d missing slot, %0d idle CPU replies; %0d CPUs halted",
             picker.n_full, picker.n_no_task, picker.n_idle, picker.n_halts);
    if (picker.errors == 0 && picker.pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
